@@ src/windowed_sample_statistics_top_macros.svh @@
// Assertion macros for the windowed sample statistics block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WINDOWED_SAMPLE_STATISTICS_TOP_MACROS_SVH
`define WINDOWED_SAMPLE_STATISTICS_TOP_MACROS_SVH

// Check a property on a given clock, disabled while the given active-low reset is low
`define WSS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the block clock and reset (clk_i / rst_ni)
`define WSS_ASSERT(lbl, prop, msg) \
  `WSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/wss_pkg.sv @@
// Shared types and constants for the windowed sample statistics block.
// No dependencies; used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package wss_pkg;

  // Window length register
  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd61;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // sample transaction this cycle
    logic div_step;  // one restoring divide step
    logic load_out;  // move finished result into the output register
  } wss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic window_done;  // the offered sample closes the window
  } wss_status_t;

endpackage

`default_nettype wire

@@ src/wss_channels_if.sv @@
// Valid/ready channel interfaces: sample input, result output, window length write.
// Depends on wss_pkg for the configuration width.
`default_nettype none

interface wss_sample_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wss_result_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                        valid;
  logic                        ready;
  logic        [SAMPLE_BITS-1:0] mean;
  logic        [SAMPLE_BITS-1:0] minimum;
  logic        [SAMPLE_BITS-1:0] maximum;
  logic signed [SAMPLE_BITS:0]   largest_step;

  modport source (output valid, output mean, output minimum, output maximum,
                  output largest_step, input ready);
  modport sink   (input valid, input mean, input minimum, input maximum,
                  input largest_step, output ready);
endinterface

interface wss_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wss_pkg::CFG_W-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

@@ src/wss_datapath.sv @@
// Datapath: window statistics registers, restoring mean divider and output register.
// Depends on wss_pkg; driven by wss_controller through command and status structs.
`default_nettype none

module wss_datapath #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned MAX_WINDOW  = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         cfg_we_i,
  input  logic [wss_pkg::CFG_W-1:0]    cfg_data_i,
  input  wss_pkg::wss_cmd_t            cmd_i,
  output wss_pkg::wss_status_t         status_o,
  output logic [SAMPLE_BITS-1:0]       mean_o,
  output logic [SAMPLE_BITS-1:0]       minimum_o,
  output logic [SAMPLE_BITS-1:0]       maximum_o,
  output logic signed [SAMPLE_BITS:0]  largest_step_o
);
  import wss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WINDOW);

  // Configuration and running statistics
  logic [CFG_W-1:0]         cfg_q;
  logic [SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]         count_q;
  logic [SAMPLE_BITS-1:0]   min_q;
  logic [SAMPLE_BITS-1:0]   max_q;
  logic [SAMPLE_BITS-1:0]   prev_q;
  logic signed [SAMPLE_BITS:0] step_q;

  // Divider and snapshot of a closed window
  logic [CNT_W-1:0]         div_rem_q;
  logic [SAMPLE_BITS-1:0]   div_quo_q;
  logic [CNT_W-1:0]         div_den_q;
  logic [SAMPLE_BITS-1:0]   snap_min_q;
  logic [SAMPLE_BITS-1:0]   snap_max_q;
  logic signed [SAMPLE_BITS:0] snap_step_q;

  // Output register
  logic [SAMPLE_BITS-1:0]   mean_q;
  logic [SAMPLE_BITS-1:0]   out_min_q;
  logic [SAMPLE_BITS-1:0]   out_max_q;
  logic signed [SAMPLE_BITS:0] out_step_q;

  // Combinational update values
  logic [LEN_W-1:0]         cfg_ext;
  logic [LEN_W-1:0]         len_eff;
  logic [CNT_W-1:0]         taken;
  logic [SUM_W-1:0]         sum_d;
  logic [SAMPLE_BITS-1:0]   min_d;
  logic [SAMPLE_BITS-1:0]   max_d;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [SAMPLE_BITS:0] diff_neg;
  logic signed [SAMPLE_BITS:0] step_neg;
  logic [SAMPLE_BITS-1:0]   diff_mag;
  logic [SAMPLE_BITS-1:0]   step_mag;
  logic signed [SAMPLE_BITS:0] step_d;
  logic [CNT_W:0]           trial;
  logic [CNT_W:0]           trial_sub;
  logic                     trial_ge;

  // Clamp the window length to 1 .. MAX_WINDOW
  always_comb begin
    cfg_ext = LEN_W'(cfg_q);
    if (cfg_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_ext > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = cfg_ext;
    end
  end

  assign taken = count_q + CNT_W'(1);
  assign status_o.window_done = (LEN_W'(taken) >= len_eff);

  // Fold the offered sample into the statistics
  always_comb begin
    sum_d    = sum_q + SUM_W'(sample_i);
    min_d    = (sample_i < min_q) ? sample_i : min_q;
    max_d    = (sample_i > max_q) ? sample_i : max_q;
    diff     = $signed({1'b0, sample_i}) - $signed({1'b0, prev_q});
    diff_neg = -diff;
    step_neg = -step_q;
    diff_mag = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
    step_mag = step_q[SAMPLE_BITS] ? step_neg[SAMPLE_BITS-1:0] : step_q[SAMPLE_BITS-1:0];
    // ties keep the older extreme; first sample of a window is not differenced
    if ((count_q != '0) && (diff_mag > step_mag)) begin
      step_d = diff;
    end else begin
      step_d = step_q;
    end
  end

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {div_rem_q, div_quo_q[SAMPLE_BITS-1]};
    trial_ge  = (trial >= {1'b0, div_den_q});
    trial_sub = trial - {1'b0, div_den_q};
  end

  // Hold the window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Advance the statistics, clear them when a window closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      prev_q  <= '0;
      step_q  <= '0;
    end else if (cmd_i.accept) begin
      if (status_o.window_done) begin
        sum_q   <= '0;
        count_q <= '0;
        min_q   <= '1;
        max_q   <= '0;
        prev_q  <= '0;
        step_q  <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= taken;
        min_q   <= min_d;
        max_q   <= max_d;
        prev_q  <= sample_i;
        step_q  <= step_d;
      end
    end
  end

  // Load the divider with the closed window, then run one quotient bit per step.
  // The mean never exceeds the largest sample, so the high dividend part is below
  // the divisor and SAMPLE_BITS steps suffice.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.window_done) begin
      div_rem_q   <= sum_d[SUM_W-1:SAMPLE_BITS];
      div_quo_q   <= sum_d[SAMPLE_BITS-1:0];
      div_den_q   <= taken;
      snap_min_q  <= min_d;
      snap_max_q  <= max_d;
      snap_step_q <= step_d;
    end else if (cmd_i.div_step) begin
      div_rem_q <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      div_quo_q <= {div_quo_q[SAMPLE_BITS-2:0], trial_ge};
    end
  end

  // Move the finished result into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_q     <= div_quo_q;
      out_min_q  <= snap_min_q;
      out_max_q  <= snap_max_q;
      out_step_q <= snap_step_q;
    end
  end

  assign mean_o         = mean_q;
  assign minimum_o      = out_min_q;
  assign maximum_o      = out_max_q;
  assign largest_step_o = out_step_q;

endmodule

`default_nettype wire

@@ src/wss_controller.sv @@
// Controller: sequences sample transactions, the mean divide and the output register.
// Depends on wss_pkg and windowed_sample_statistics_top_macros.svh.
`default_nettype none

`include "windowed_sample_statistics_top_macros.svh"

module wss_controller #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  wss_pkg::wss_status_t  status_i,
  output wss_pkg::wss_cmd_t     cmd_o
);
  import wss_pkg::*;

  localparam int unsigned ITER_W = $clog2(SAMPLE_BITS);
  localparam logic [ITER_W-1:0] LastIter = ITER_W'(SAMPLE_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e            state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // Decode commands from the current state and handshakes
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.accept    = in_valid_i && in_ready_o;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.load_out  = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);
  end

  // Next state, step counter and output valid
  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && status_i.window_done) begin
          state_d = ST_DIV;
          iter_d  = '0;
        end
      end
      ST_DIV: begin
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == LastIter) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (cmd_o.load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `WSS_ASSERT(a_close_starts_div, cmd_o.accept && status_i.window_done |=> cmd_o.div_step, "closing sample did not start the divide")
  `WSS_ASSERT(a_load_needs_room, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result loaded over an untaken result")
  `WSS_ASSERT(a_no_accept_in_div, cmd_o.div_step |-> !in_ready_o, "sample taken while divider busy")
  `WSS_ASSERT(a_div_length, (state_q == ST_DIV) && (iter_q == LastIter) |=> (state_q == ST_HOLD), "divide did not end after its last step")

endmodule

`default_nettype wire

@@ src/windowed_sample_statistics_top.sv @@
// Top level of the windowed sample statistics block: controller, datapath and channels.
// Depends on wss_pkg, wss_channels_if, wss_controller and wss_datapath.
//
//   channel    dir  payload                                       transaction
//   sample_i   in   sample                                        valid & ready
//   result_o   out  mean, minimum, maximum, largest_step          valid & ready
//   cfg_i      in   window_length                                 valid & ready (always ready)
//
// A sample that does not close its window leaves the input ready for the next sample.
// A closing sample stalls the input through SAMPLE_BITS divide steps and the hold
// state: the mean comes from a restoring divider that resolves one quotient bit per cycle.
// Reset clears all window statistics at once and sets window_length to 61.
// A finished result waits in the output register while the next window fills; after a
// further closing sample and its divide, the input stalls until that register is free.
`default_nettype none

module windowed_sample_statistics_top #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned MAX_WINDOW  = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wss_sample_if.sink   sample_i,
  wss_result_if.source result_o,
  wss_cfg_if.sink      cfg_i
);
  import wss_pkg::*;

  wss_cmd_t    cmd;
  wss_status_t status;

  // Configuration writes are taken in any cycle
  assign cfg_i.ready = 1'b1;

  // Sequence the transactions
  wss_controller #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Statistics, divider and output register
  wss_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i.sample),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.window_length),
    .cmd_i          (cmd),
    .status_o       (status),
    .mean_o         (result_o.mean),
    .minimum_o      (result_o.minimum),
    .maximum_o      (result_o.maximum),
    .largest_step_o (result_o.largest_step)
  );

endmodule

`default_nettype wire
